/* rtl/crawf_pkg.sv */
// Package: opcodes, flags, widths and register-file helpers for the register ALU.
`timescale 1ns / 1ps
`default_nettype none

package crawf_pkg;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_AND    = 5'd4,
    OP_XOR    = 5'd5,
    OP_OR     = 5'd6,
    OP_CP     = 5'd7,
    OP_INC    = 5'd8,
    OP_DEC    = 5'd9,
    OP_RLC    = 5'd10,
    OP_RRC    = 5'd11,
    OP_RL     = 5'd12,
    OP_RR     = 5'd13,
    OP_SLA    = 5'd14,
    OP_SRA    = 5'd15,
    OP_SRL    = 5'd16,
    OP_SWAP   = 5'd17,
    OP_BIT    = 5'd18,
    OP_RES    = 5'd19,
    OP_SET    = 5'd20,
    OP_INC16  = 5'd21,
    OP_DEC16  = 5'd22,
    OP_ADD16  = 5'd23,
    OP_LOAD8  = 5'd24,
    OP_LOAD16 = 5'd25
  } op_t;

  // register selectors
  localparam logic [2:0] SEL_A   = 3'd0;
  localparam logic [2:0] SEL_AF  = 3'd0;
  localparam logic [2:0] SEL_MEM = 3'd7;
  localparam logic [2:0] SEL_16_LIMIT = 3'd6;

  // flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam int IN_WIDTH  = 40;
  localparam int OUT_WIDTH = 24;

  // register file: one 16-bit word per pair (A_, BC, DE, HL, SP, PC, two unused)
  localparam int RF_DEPTH = 8;
  localparam int RF_AW    = $clog2(RF_DEPTH);

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] addr;
    logic [15:0]      data;
  } rf_write_t;

  // pair holding an 8-bit register: A->0, B/C->1, D/E->2, H/L->3
  function automatic logic [RF_AW-1:0] byte_pair(input logic [2:0] sel);
    byte_pair = {1'b0, sel[2:1]} + {2'b00, sel[0]};
  endfunction

  // A, B, D and H sit in the high byte of their pair
  function automatic logic byte_high(input logic [2:0] sel);
    byte_high = sel[0] | (sel == SEL_A);
  endfunction

endpackage

`default_nettype wire

/* rtl/cpu_register_alu_with_flags.sv */
// Top level: register file, ALU and flag logic of an 8-bit CPU core with a stream interface.
`timescale 1ns / 1ps
`default_nettype none

// One item per clock cycle sustained unless the output stalls; items pass the execute stage,
// then the output register. The register pairs (A, BC, DE, HL, SP, PC) live in an 8 x 16-bit
// memory with two registered read ports and one write port: an item reads its destination and
// source pairs in the accept cycle, computes and writes back as it leaves the execute stage, and
// a one-entry forward of the most recent write covers the read that overlaps it. The flags are
// kept in a register beside the memory. Per-entry valid bits make every register read as zero
// after reset, so no clearing pass is needed. The output register is loaded whenever it is empty
// or being taken, so a stall downstream holds the pipeline only as long as it lasts.
module cpu_register_alu_with_flags (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // opcode[4:0], dest_sel[7:5], src_sel[10:8], mem_value[18:11], bit_index[21:19],
  // load_value[37:22], zero[39:38]
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // result_value[15:0], mem_write[16], flag_bits[20:17], zero[23:21]
  output logic [23:0]      m_tdata
);

  localparam int AW = crawf_pkg::RF_AW;

  // input fields
  logic [4:0]  in_op;
  logic [2:0]  in_ds;
  logic [2:0]  in_ss;
  logic        in_is16;
  logic [AW-1:0] in_addr_a;
  logic [AW-1:0] in_addr_b;

  assign in_op = s_tdata[4:0];
  assign in_ds = s_tdata[7:5];
  assign in_ss = s_tdata[10:8];

  always_comb begin
    in_is16 = (in_op == crawf_pkg::OP_INC16) || (in_op == crawf_pkg::OP_DEC16) ||
              (in_op == crawf_pkg::OP_ADD16) || (in_op == crawf_pkg::OP_LOAD16);
    in_addr_a = in_is16 ? in_ds : crawf_pkg::byte_pair(in_ds);
    in_addr_b = in_is16 ? in_ss : crawf_pkg::byte_pair(in_ss);
  end

  // handshake
  logic accept;
  logic fire;
  logic out_free;
  logic s1_valid;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = s1_valid && out_free;
  assign s_tready = !s1_valid || fire;
  assign accept   = s_tvalid && s_tready;

  // register file memory
  logic [15:0]    rf_mem [crawf_pkg::RF_DEPTH];
  logic [crawf_pkg::RF_DEPTH-1:0] rf_valid;
  logic [15:0]    rd_a;
  logic [15:0]    rd_b;
  crawf_pkg::rf_write_t wr;
  crawf_pkg::rf_write_t last_wr;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a <= rf_valid[in_addr_a] ? rf_mem[in_addr_a] : 16'h0000;
      rd_b <= rf_valid[in_addr_b] ? rf_mem[in_addr_b] : 16'h0000;
    end
    if (fire && wr.en) begin
      rf_mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      last_wr  <= '0;
    end else if (fire && wr.en) begin
      rf_valid[wr.addr] <= 1'b1;
      last_wr           <= wr;
    end
  end

  // execute-stage item
  crawf_pkg::op_t s1_op;
  logic [2:0]     s1_ds;
  logic [2:0]     s1_ss;
  logic [7:0]     s1_mem;
  logic [2:0]     s1_bi;
  logic [15:0]    s1_ld;
  logic [AW-1:0]  s1_addr_a;
  logic [AW-1:0]  s1_addr_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= crawf_pkg::op_t'(in_op);
      s1_ds     <= in_ds;
      s1_ss     <= in_ss;
      s1_mem    <= s_tdata[18:11];
      s1_bi     <= s_tdata[21:19];
      s1_ld     <= s_tdata[37:22];
      s1_addr_a <= in_addr_a;
      s1_addr_b <= in_addr_b;
    end
  end

  // the write made in the accept cycle is not yet in the read data; forwarding an older
  // write is harmless since the memory already holds the same word
  logic [15:0] word_a;
  logic [15:0] word_b;

  always_comb begin
    word_a = (last_wr.en && last_wr.addr == s1_addr_a) ? last_wr.data : rd_a;
    word_b = (last_wr.en && last_wr.addr == s1_addr_b) ? last_wr.data : rd_b;
  end

  // ALU
  logic [3:0]  flags;
  logic [3:0]  f;
  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [15:0] a16;
  logic [15:0] b16;
  logic        cin;
  logic        t;
  logic [8:0]  sum9;
  logic [4:0]  nib5;
  logic [16:0] sum17;
  logic [12:0] low13;
  logic [7:0]  r8;
  logic [15:0] r16;
  logic [15:0] res;
  logic        w8;
  logic        w16;
  logic        mw;

  always_comb begin
    cin = flags[crawf_pkg::FLAG_C];
    a8  = (s1_ds == crawf_pkg::SEL_MEM) ? s1_mem :
          (crawf_pkg::byte_high(s1_ds) ? word_a[15:8] : word_a[7:0]);
    b8  = (s1_ss == crawf_pkg::SEL_MEM) ? s1_mem :
          (crawf_pkg::byte_high(s1_ss) ? word_b[15:8] : word_b[7:0]);
    a16 = (s1_ds == crawf_pkg::SEL_AF) ? {word_a[15:8], flags, 4'h0} :
          ((s1_ds < crawf_pkg::SEL_16_LIMIT) ? word_a : 16'h0000);
    b16 = (s1_ss == crawf_pkg::SEL_AF) ? {word_b[15:8], flags, 4'h0} :
          ((s1_ss < crawf_pkg::SEL_16_LIMIT) ? word_b : 16'h0000);

    f     = flags;
    t     = 1'b0;
    sum9  = '0;
    nib5  = '0;
    sum17 = '0;
    low13 = '0;
    r8    = '0;
    r16   = '0;
    res   = '0;
    w8    = 1'b0;
    w16   = 1'b0;

    case (s1_op)
      crawf_pkg::OP_ADD, crawf_pkg::OP_ADC: begin
        t    = (s1_op == crawf_pkg::OP_ADC) & cin;
        sum9 = {1'b0, a8} + {1'b0, b8} + {8'h00, t};
        nib5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, t};
        r8   = sum9[7:0];
        f    = {r8 == 8'h00, 1'b0, nib5[4], sum9[8]};
        w8   = 1'b1;
      end
      crawf_pkg::OP_SUB, crawf_pkg::OP_SBC, crawf_pkg::OP_CP: begin
        t    = (s1_op == crawf_pkg::OP_SBC) & cin;
        sum9 = {1'b0, a8} - {1'b0, b8} - {8'h00, t};
        nib5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'h0, t};
        r8   = sum9[7:0];
        f    = {r8 == 8'h00, 1'b1, nib5[4], sum9[8]};
        if (s1_op == crawf_pkg::OP_CP) begin
          res = {8'h00, a8};
        end else begin
          w8 = 1'b1;
        end
      end
      crawf_pkg::OP_AND: begin
        r8 = a8 & b8;
        f  = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
        w8 = 1'b1;
      end
      crawf_pkg::OP_XOR: begin
        r8 = a8 ^ b8;
        f  = {r8 == 8'h00, 3'b000};
        w8 = 1'b1;
      end
      crawf_pkg::OP_OR: begin
        r8 = a8 | b8;
        f  = {r8 == 8'h00, 3'b000};
        w8 = 1'b1;
      end
      crawf_pkg::OP_INC: begin
        r8 = a8 + 8'd1;
        f  = {r8 == 8'h00, 1'b0, a8[3:0] == 4'hF, cin};
        w8 = 1'b1;
      end
      crawf_pkg::OP_DEC: begin
        r8 = a8 - 8'd1;
        f  = {r8 == 8'h00, 1'b1, a8[3:0] == 4'h0, cin};
        w8 = 1'b1;
      end
      crawf_pkg::OP_RLC: begin
        r8 = {a8[6:0], a8[7]};
        f  = {r8 == 8'h00, 2'b00, a8[7]};
        w8 = 1'b1;
      end
      crawf_pkg::OP_RRC: begin
        r8 = {a8[0], a8[7:1]};
        f  = {r8 == 8'h00, 2'b00, a8[0]};
        w8 = 1'b1;
      end
      crawf_pkg::OP_RL: begin
        r8 = {a8[6:0], cin};
        f  = {r8 == 8'h00, 2'b00, a8[7]};
        w8 = 1'b1;
      end
      crawf_pkg::OP_RR: begin
        r8 = {cin, a8[7:1]};
        f  = {r8 == 8'h00, 2'b00, a8[0]};
        w8 = 1'b1;
      end
      crawf_pkg::OP_SLA: begin
        r8 = {a8[6:0], 1'b0};
        f  = {r8 == 8'h00, 2'b00, a8[7]};
        w8 = 1'b1;
      end
      crawf_pkg::OP_SRA: begin
        r8 = {a8[7], a8[7:1]};
        f  = {r8 == 8'h00, 2'b00, a8[0]};
        w8 = 1'b1;
      end
      crawf_pkg::OP_SRL: begin
        r8 = {1'b0, a8[7:1]};
        f  = {r8 == 8'h00, 2'b00, a8[0]};
        w8 = 1'b1;
      end
      crawf_pkg::OP_SWAP: begin
        r8 = {a8[3:0], a8[7:4]};
        f  = {r8 == 8'h00, 3'b000};
        w8 = 1'b1;
      end
      crawf_pkg::OP_BIT: begin
        f   = {!a8[s1_bi], 1'b0, 1'b1, cin};
        res = {8'h00, a8};
      end
      crawf_pkg::OP_RES: begin
        r8 = a8 & ~(8'h01 << s1_bi);
        w8 = 1'b1;
      end
      crawf_pkg::OP_SET: begin
        r8 = a8 | (8'h01 << s1_bi);
        w8 = 1'b1;
      end
      crawf_pkg::OP_LOAD8: begin
        r8 = s1_ld[7:0];
        w8 = 1'b1;
      end
      crawf_pkg::OP_INC16: begin
        r16 = a16 + 16'd1;
        w16 = 1'b1;
      end
      crawf_pkg::OP_DEC16: begin
        r16 = a16 - 16'd1;
        w16 = 1'b1;
      end
      crawf_pkg::OP_LOAD16: begin
        r16 = s1_ld;
        w16 = 1'b1;
      end
      crawf_pkg::OP_ADD16: begin
        sum17 = {1'b0, a16} + {1'b0, b16};
        low13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        r16   = sum17[15:0];
        f     = {flags[crawf_pkg::FLAG_Z], 1'b0, low13[12], sum17[16]};
        res   = r16;  // shown as is when the destination is an unused selector
        w16   = 1'b1;
      end
      default: begin
        res = 16'h0000;
      end
    endcase

    // write-back; an 8-bit store keeps the other byte of its pair
    wr = '0;
    mw = 1'b0;
    if (w8) begin
      res = {8'h00, r8};
      if (s1_ds == crawf_pkg::SEL_MEM) begin
        mw = 1'b1;
      end else begin
        wr.en   = 1'b1;
        wr.addr = s1_addr_a;
        wr.data = crawf_pkg::byte_high(s1_ds) ? {r8, word_a[7:0]} : {word_a[15:8], r8};
      end
    end else if (w16 && s1_ds < crawf_pkg::SEL_16_LIMIT) begin
      wr.en   = 1'b1;
      wr.addr = s1_addr_a;
      wr.data = r16;
      if (s1_ds == crawf_pkg::SEL_AF) begin
        // flags written through AF win over the computed ones
        f   = r16[7:4];
        res = {r16[15:4], 4'h0};
      end else begin
        res = r16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= 4'h0;
    end else if (fire) begin
      flags <= f;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {3'b000, f, mw, res};
    end
  end

endmodule

`default_nettype wire
